[hw/rtl/solar_daylight_test_defines.svh]
// assertion macros shared by the rtl
`ifndef SOLAR_DAYLIGHT_TEST_DEFINES_SVH
`define SOLAR_DAYLIGHT_TEST_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/slt_pkg.sv]
package slt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PH_W      = 32;
  localparam int XW        = FRAC_BITS + 3;
  localparam int DAY_W     = 9;
  localparam int SEC_W     = 17;
  localparam int LAT_W     = 15;
  localparam int LAT_MAG_W = 14;
  localparam int LON_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCATION  = 2'd0,
    CFG_LATITUDE  = 2'd1,
    CFG_LONGITUDE = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    SUN_NORMAL      = 2'd0,
    SUN_POLAR_NIGHT = 2'd1,
    SUN_POLAR_DAY   = 2'd2,
    SUN_NO_LOCATION = 2'd3
  } sun_case_t;

  localparam logic signed [XW-1:0] CORDIC_X0 = XW'(64'd652032874 >> (30 - FRAC_BITS));
  localparam logic signed [29:0]   DECL_AMP  = 30'sd279650093;
  localparam logic signed [LAT_W-1:0] LAT_MAX = 15'sd9000;

  // turn = q * step + floor((q * rem + half) / div), reciprocal for the last part
  localparam logic [31:0] YEAR_STEP  = 32'd11767033;
  localparam logic [16:0] YEAR_REM   = 17'd251;
  localparam logic [16:0] YEAR_HALF  = 17'd182;
  localparam logic [33:0] YEAR_RECIP = 34'd91930;
  localparam int          YEAR_SHIFT = 25;

  localparam logic [31:0] ANG_STEP   = 32'd119304;
  localparam logic [29:0] ANG_REM    = 30'd23296;
  localparam logic [29:0] ANG_HALF   = 30'd18000;
  localparam logic [59:0] ANG_RECIP  = 60'd977343670;
  localparam int          ANG_SHIFT  = 45;

  localparam logic [31:0] SEC_STEP   = 32'd49710;
  localparam logic [31:0] SEC_REM    = 32'd23296;
  localparam logic [31:0] SEC_HALF   = 32'd43200;
  localparam logic [63:0] SEC_RECIP  = 64'd3257812231;
  localparam int          SEC_SHIFT  = 48;

  localparam logic [PH_W-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [31:0] TURN_ATAN [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage

[hw/rtl/slt_query_if.sv]
interface slt_query_if import slt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DAY_W-1:0] day_of_year;
  logic [SEC_W-1:0] second_of_day;

  modport source (output valid, output day_of_year, output second_of_day, input ready);
  modport sink   (input valid, input day_of_year, input second_of_day, output ready);
endinterface

[hw/rtl/slt_answer_if.sv]
interface slt_answer_if import slt_pkg::*; ();
  logic      valid;
  logic      ready;
  logic      is_day;
  sun_case_t sun_case;

  modport source (output valid, output is_day, output sun_case, input ready);
  modport sink   (input valid, input is_day, input sun_case, output ready);
endinterface

[hw/rtl/slt_cordic.sv]
module slt_cordic import slt_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [PH_W-1:0]      phase,
  output logic signed [XW-1:0] cos_val,
  output logic signed [XW-1:0] sin_val
);

  localparam int RW = PH_W + 2;
  localparam logic signed [RW-1:0] QTR = RW'(2 ** (PH_W - 2));
  localparam logic signed [RW-1:0] HALF = QTR <<< 1;

  logic signed [RW-1:0] rin;
  logic signed [RW-1:0] r0;
  logic                 flip0;

  logic signed [XW-1:0] xs [FRAC_BITS];
  logic signed [XW-1:0] ys [FRAC_BITS];
  logic signed [RW-1:0] rs [FRAC_BITS];
  logic                 fl [FRAC_BITS];

  assign rin = RW'(signed'(phase));

  // fold into the right half plane, both outputs negate
  always_comb begin
    r0    = rin;
    flip0 = 1'b0;
    if (rin > QTR) begin
      r0    = rin - HALF;
      flip0 = 1'b1;
    end else if (rin < -QTR) begin
      r0    = rin + HALF;
      flip0 = 1'b1;
    end
  end

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_iter
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [RW-1:0] ri;
    logic                 fi;
    logic signed [RW-1:0] ai;

    if (i == 0) begin : g_first
      assign xi = CORDIC_X0;
      assign yi = '0;
      assign ri = r0;
      assign fi = flip0;
    end else begin : g_next
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign ri = rs[i-1];
      assign fi = fl[i-1];
    end

    assign ai = signed'({2'b00, TURN_ATAN[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        if (ri >= 0) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          rs[i] <= ri - ai;
        end else begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          rs[i] <= ri + ai;
        end
        fl[i] <= fi;
      end
    end
  end

  assign cos_val = fl[FRAC_BITS-1] ? -xs[FRAC_BITS-1] : xs[FRAC_BITS-1];
  assign sin_val = fl[FRAC_BITS-1] ? -ys[FRAC_BITS-1] : ys[FRAC_BITS-1];

endmodule

[hw/rtl/solar_daylight_test.sv]
// Sun-up test by the simplified sunrise equation.
// query channel: one request carries day_of_year and second_of_day (UTC).
// answer channel: one result per request, in order: is_day and sun_case
// (normal, polar night, polar day, location unknown).
// Configuration: cfg_we with cfg_index 0 location_known, 1 latitude,
// 2 longitude (centidegrees, signed); index 3 is ignored. Write only while
// no request is in flight.
// The pipe has four stages of phase arithmetic, one CORDIC iteration per
// stage for the declination sine, two stages for the declination angle,
// a second CORDIC row (declination, latitude and hour angle side by
// side), and four stages for the products and the final compare.
// Throughput is one request per cycle while the answer is not stalled.
// Reset clears the configuration (location unknown) and empties the pipe.
// A stalled answer freezes the whole pipe; query.ready drops whenever an
// answer is held, so nothing is lost or repeated.
`include "solar_daylight_test_defines.svh"

module solar_daylight_test import slt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  slt_query_if.sink            query,
  slt_answer_if.source         answer
);

  localparam int DEPTH = 2 * FRAC_BITS + 10;
  localparam int PW    = 2 * XW;

  logic                    location_known;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;

  logic             adv;
  logic [DEPTH:1]   vld;

  // stage 1
  logic [9:0]              t_day;
  logic [DAY_W-1:0]        k_next;
  logic signed [LAT_W-1:0] lat_cl;
  logic [LAT_MAG_W-1:0]    lat_mag_next;
  logic [LON_W:0]          lon_ext;
  logic [LON_W-1:0]        lon_mag_next;
  logic [DAY_W-1:0]        k1;
  logic [SEC_W-1:0]        sec1;
  logic [LAT_MAG_W-1:0]    lat_m1;
  logic                    lat_n1;
  logic [LON_W-1:0]        lon_m1;
  logic                    lon_n1;

  // stage 2
  logic [16:0] yv2;
  logic [31:0] yb2;
  logic [29:0] latv2;
  logic [31:0] latb2;
  logic [29:0] lonv2;
  logic [31:0] lonb2;
  logic [31:0] secv2;
  logic [31:0] secb2;
  logic        lat_n2;
  logic        lon_n2;

  // stage 3
  logic [33:0] yp3;
  logic [31:0] yb3;
  logic [59:0] latp3;
  logic [31:0] latb3;
  logic [59:0] lonp3;
  logic [31:0] lonb3;
  logic [63:0] secp3;
  logic [31:0] secb3;
  logic        lat_n3;
  logic        lon_n3;

  // stage 4
  logic [PH_W-1:0] lat_mag;
  logic [PH_W-1:0] lon_mag;
  logic [PH_W-1:0] yph4;
  logic [PH_W-1:0] latph4;
  logic [PH_W-1:0] lonph4;
  logic [PH_W-1:0] secph4;
  logic [PH_W-1:0] hph;

  logic [PH_W-1:0] lat_dly [FRAC_BITS];
  logic [PH_W-1:0] hr_dly  [FRAC_BITS];

  logic signed [XW-1:0] cos_a;
  logic signed [XW-1:0] sin_a;

  logic signed [XW+29:0] dp21;
  logic [PH_W-1:0]       lat21;
  logic [PH_W-1:0]       hr21;
  logic signed [XW+29:0] dp_rnd;
  logic [PH_W-1:0]       dph22;
  logic [PH_W-1:0]       lat22;
  logic [PH_W-1:0]       hr22;

  logic signed [XW-1:0] cd;
  logic signed [XW-1:0] sd;
  logic signed [XW-1:0] cl;
  logic signed [XW-1:0] sl;
  logic signed [XW-1:0] ch;
  logic signed [XW-1:0] sh;
  logic signed [XW-1:0] cd_pos;
  logic signed [XW-1:0] cl_pos;

  logic signed [PW-1:0] pn39;
  logic signed [PW-1:0] pd39;
  logic signed [XW-1:0] ch39;
  logic signed [PW-1:0] num_rnd;
  logic signed [PW-1:0] den_rnd;
  logic signed [XW-1:0] num40;
  logic signed [XW-1:0] den40;
  logic signed [XW-1:0] ch40;
  logic signed [PW-1:0] pr41;
  logic signed [XW-1:0] num41;
  logic signed [XW-1:0] den41;
  logic signed [PW-1:0] num_scaled;

  logic      is_day;
  sun_case_t sun_case;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      location_known <= 1'b0;
      latitude       <= '0;
      longitude      <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_LOCATION:  location_known <= cfg_data[0];
        CFG_LATITUDE:  latitude       <= cfg_data[LAT_W-1:0];
        CFG_LONGITUDE: longitude      <= cfg_data[LON_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = !vld[DEPTH] || answer.ready;
  assign query.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-1:1], query.valid};
    end
  end

  // stage 1: day wrap, latitude clamp, magnitudes
  always_comb begin
    t_day = 10'(query.day_of_year) + 10'd284;
    if (t_day >= 10'd730) begin
      k_next = DAY_W'(t_day - 10'd730);
    end else if (t_day >= 10'd365) begin
      k_next = DAY_W'(t_day - 10'd365);
    end else begin
      k_next = DAY_W'(t_day);
    end
    lat_cl = latitude;
    if (latitude > LAT_MAX) begin
      lat_cl = LAT_MAX;
    end else if (latitude < -LAT_MAX) begin
      lat_cl = -LAT_MAX;
    end
    lat_mag_next = lat_cl[LAT_W-1] ? LAT_MAG_W'(-lat_cl) : LAT_MAG_W'(lat_cl);
    lon_ext      = {longitude[LON_W-1], longitude};
    lon_mag_next = longitude[LON_W-1] ? LON_W'(-lon_ext) : LON_W'(lon_ext);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1     <= k_next;
      sec1   <= query.second_of_day;
      lat_m1 <= lat_mag_next;
      lat_n1 <= lat_cl[LAT_W-1];
      lon_m1 <= lon_mag_next;
      lon_n1 <= longitude[LON_W-1];
    end
  end

  // stage 2: whole turns and remainders
  always_ff @(posedge clk) begin
    if (adv) begin
      yv2    <= 17'(k1) * YEAR_REM + YEAR_HALF;
      yb2    <= 32'(k1) * YEAR_STEP;
      latv2  <= 30'(lat_m1) * ANG_REM + ANG_HALF;
      latb2  <= 32'(lat_m1) * ANG_STEP;
      lonv2  <= 30'(lon_m1) * ANG_REM + ANG_HALF;
      lonb2  <= 32'(lon_m1) * ANG_STEP;
      secv2  <= 32'(sec1) * SEC_REM + SEC_HALF;
      secb2  <= 32'(sec1) * SEC_STEP;
      lat_n2 <= lat_n1;
      lon_n2 <= lon_n1;
    end
  end

  // stage 3: remainder division by reciprocal
  always_ff @(posedge clk) begin
    if (adv) begin
      yp3    <= 34'(yv2) * YEAR_RECIP;
      yb3    <= yb2;
      latp3  <= 60'(latv2) * ANG_RECIP;
      latb3  <= latb2;
      lonp3  <= 60'(lonv2) * ANG_RECIP;
      lonb3  <= lonb2;
      secp3  <= 64'(secv2) * SEC_RECIP;
      secb3  <= secb2;
      lat_n3 <= lat_n2;
      lon_n3 <= lon_n2;
    end
  end

  // stage 4: phases
  assign lat_mag = latb3 + PH_W'(latp3 >> ANG_SHIFT);
  assign lon_mag = lonb3 + PH_W'(lonp3 >> ANG_SHIFT);

  always_ff @(posedge clk) begin
    if (adv) begin
      yph4   <= yb3 + PH_W'(yp3 >> YEAR_SHIFT);
      latph4 <= lat_n3 ? -lat_mag : lat_mag;
      lonph4 <= lon_n3 ? -lon_mag : lon_mag;
      secph4 <= secb3 + PH_W'(secp3 >> SEC_SHIFT);
    end
  end

  // solar noon sits at hour angle zero
  assign hph = secph4 + HALF_TURN + lonph4;

  slt_cordic u_year (
    .clk     (clk),
    .en      (adv),
    .phase   (yph4),
    .cos_val (cos_a),
    .sin_val (sin_a)
  );

  // hold latitude and hour phases while the year sine is worked out
  always_ff @(posedge clk) begin
    if (adv) begin
      lat_dly[0] <= latph4;
      hr_dly[0]  <= hph;
      for (int i = 1; i < FRAC_BITS; i++) begin
        lat_dly[i] <= lat_dly[i-1];
        hr_dly[i]  <= hr_dly[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dp21  <= DECL_AMP * sin_a;
      lat21 <= lat_dly[FRAC_BITS-1];
      hr21  <= hr_dly[FRAC_BITS-1];
    end
  end

  assign dp_rnd = dp21 + (XW+30)'(2 ** (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      dph22 <= PH_W'(dp_rnd >>> FRAC_BITS);
      lat22 <= lat21;
      hr22  <= hr21;
    end
  end

  slt_cordic u_decl (
    .clk     (clk),
    .en      (adv),
    .phase   (dph22),
    .cos_val (cd),
    .sin_val (sd)
  );

  slt_cordic u_lat (
    .clk     (clk),
    .en      (adv),
    .phase   (lat22),
    .cos_val (cl),
    .sin_val (sl)
  );

  slt_cordic u_hour (
    .clk     (clk),
    .en      (adv),
    .phase   (hr22),
    .cos_val (ch),
    .sin_val (sh)
  );

  assign cd_pos = (cd < 0) ? '0 : cd;
  assign cl_pos = (cl < 0) ? '0 : cl;

  always_ff @(posedge clk) begin
    if (adv) begin
      pn39 <= PW'(sl) * PW'(sd);
      pd39 <= PW'(cl_pos) * PW'(cd_pos);
      ch39 <= ch;
    end
  end

  assign num_rnd = -pn39 + PW'(2 ** (FRAC_BITS - 1));
  assign den_rnd = pd39 + PW'(2 ** (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      num40 <= XW'(num_rnd >>> FRAC_BITS);
      den40 <= XW'(den_rnd >>> FRAC_BITS);
      ch40  <= ch39;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr41  <= PW'(ch40) * PW'(den40);
      num41 <= num40;
      den41 <= den40;
    end
  end

  assign num_scaled = PW'(num41) <<< FRAC_BITS;

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!location_known) begin
        is_day   <= 1'b1;
        sun_case <= SUN_NO_LOCATION;
      end else if (num41 > den41) begin
        is_day   <= 1'b0;
        sun_case <= SUN_POLAR_NIGHT;
      end else if (num41 < -den41) begin
        is_day   <= 1'b1;
        sun_case <= SUN_POLAR_DAY;
      end else begin
        is_day   <= (pr41 >= num_scaled);
        sun_case <= SUN_NORMAL;
      end
    end
  end

  assign answer.valid    = vld[DEPTH];
  assign answer.is_day   = is_day;
  assign answer.sun_case = sun_case;

  `SLT_ASSERT_NOW(a_no_location, answer.valid && !location_known,
    answer.is_day && answer.sun_case == SUN_NO_LOCATION, "unknown location must give day")
  `SLT_ASSERT_NOW(a_polar_night, answer.valid && answer.sun_case == SUN_POLAR_NIGHT,
    !answer.is_day, "polar night reported as day")
  `SLT_ASSERT_NOW(a_polar_day, answer.valid && answer.sun_case == SUN_POLAR_DAY,
    answer.is_day, "polar day reported as night")
  `SLT_ASSERT_NEXT(a_accept_enters, query.valid && query.ready, vld[1],
    "accepted request not in pipe")

endmodule

[dv/tb_solar_daylight_test.sv]
`timescale 1ns / 100ps

module tb_solar_daylight_test;
  import slt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 2 * FRAC_BITS + 20;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 195;

  typedef struct packed {
    logic      is_day;
    sun_case_t sun_case;
  } sun_answer_t;

  class sun_scoreboard;
    sun_answer_t answer_q[$];
    int errors;
    int noted;
    logic known;
    longint lat_cd;
    longint lon_cd;

    function new();
      errors = 0;
      noted  = 0;
      known  = 0;
      lat_cd = 0;
      lon_cd = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_LOCATION:  known = data[0];
        CFG_LATITUDE:  lat_cd = longint'(signed'(data[LAT_W-1:0]));
        CFG_LONGITUDE: lon_cd = longint'(signed'(data[LON_W-1:0]));
        default: ;
      endcase
    endfunction

    function longint round_frac(longint v);
      return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function logic [31:0] turn_of(longint v, longint div);
      longint mag, q;
      mag = (v < 0) ? -v : v;
      q = ((mag <<< 32) + div / 2) / div;
      if (v < 0) q = -q;
      return q[31:0];
    endfunction

    // cordic rotation, phase folded into [-1/4, 1/4] turn first
    function void rotate(logic [31:0] p, output longint c, output longint s);
      longint r, x, y, dx, dy;
      bit flip;
      r = p[31] ? longint'(p) - 64'sd4294967296 : longint'(p);
      flip = 0;
      if (r > 64'sd1073741824) begin
        r -= 64'sd2147483648;
        flip = 1;
      end else if (r < -64'sd1073741824) begin
        r += 64'sd2147483648;
        flip = 1;
      end
      x = 64'sd652032874 >>> (30 - FRAC_BITS);
      y = 0;
      for (int i = 0; i < FRAC_BITS && i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (r >= 0) begin
          x -= dx;
          y += dy;
          r -= longint'(TURN_ATAN[i]);
        end else begin
          x += dx;
          y -= dy;
          r += longint'(TURN_ATAN[i]);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function sun_answer_t sun_state(logic [DAY_W-1:0] day, logic [SEC_W-1:0] sec);
      sun_answer_t a;
      longint k, c, s, cd, sd, cl, sl, ch, sh, lat, num, den;
      logic [31:0] ph;
      if (!known) begin
        a.is_day = 1;
        a.sun_case = SUN_NO_LOCATION;
        return a;
      end
      k = (284 + longint'(day)) % 365;
      rotate(32'(((k <<< 32) + 182) / 365), c, s);
      ph = 32'(round_frac(longint'(DECL_AMP) * s));
      rotate(ph, cd, sd);
      lat = lat_cd;
      if (lat > 9000) lat = 9000;
      if (lat < -9000) lat = -9000;
      rotate(turn_of(lat, 36000), cl, sl);
      if (cl < 0) cl = 0;
      if (cd < 0) cd = 0;
      num = round_frac(-(sl * sd));
      den = round_frac(cl * cd);
      if (num > den) begin
        a.is_day = 0;
        a.sun_case = SUN_POLAR_NIGHT;
        return a;
      end
      if (num < -den) begin
        a.is_day = 1;
        a.sun_case = SUN_POLAR_DAY;
        return a;
      end
      ph = turn_of(longint'(sec), 86400) + HALF_TURN + turn_of(lon_cd, 36000);
      rotate(ph, ch, sh);
      a.is_day = (ch * den >= (num <<< FRAC_BITS));
      a.sun_case = SUN_NORMAL;
      return a;
    endfunction

    function void note_request(logic [DAY_W-1:0] day, logic [SEC_W-1:0] sec);
      answer_q.push_back(sun_state(day, sec));
      noted++;
    endfunction

    task check_answer(logic is_day, sun_case_t sc);
      sun_answer_t want;
      if (answer_q.size() == 0) begin
        report("answer with no request pending");
        return;
      end
      want = answer_q.pop_front();
      if (is_day !== want.is_day)
        report($sformatf("is_day %0b, expected %0b", is_day, want.is_day));
      if (sc !== want.sun_case)
        report($sformatf("sun_case %0d, expected %0d", sc, want.sun_case));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  slt_query_if  query ();
  slt_answer_if answer ();

  solar_daylight_test u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .query     (query),
    .answer    (answer)
  );

  sun_scoreboard sb = new();
  int burst_left = 0;
  int cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_solar_daylight_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && answer.valid && answer.ready)
      sb.check_answer(answer.is_day, answer.sun_case);

  // receiver: changing stall patterns, plus one long hold-off to fill the pipe
  initial begin
    int mode;
    bit held;
    answer.ready <= 0;
    held = 0;
    mode = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && sb.noted >= 600) begin
        held = 1;
        answer.ready <= 0;
        repeat (300) @(posedge clk);
      end else begin
        if ($urandom_range(0, 150) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: answer.ready <= 1;
          1: answer.ready <= ($urandom_range(0, 9) < 7);
          default: answer.ready <= (cycles % 5 != 0);
        endcase
      end
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, data);
  endtask

  // caller is at a clock edge; valid stays high across a burst
  task send_request(logic [DAY_W-1:0] day, logic [SEC_W-1:0] sec);
    query.valid <= 1;
    query.day_of_year <= day;
    query.second_of_day <= sec;
    do @(posedge clk); while (!query.ready);
    sb.note_request(day, sec);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 40);
      query.valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task send_random(int n);
    logic [DAY_W-1:0] day;
    logic [SEC_W-1:0] sec;
    for (int i = 0; i < n; i++) begin
      day = ($urandom_range(0, 9) == 0) ? DAY_W'($urandom_range(0, 511))
                                        : DAY_W'($urandom_range(1, 366));
      sec = ($urandom_range(0, 9) == 0) ? SEC_W'($urandom_range(0, 131071))
                                        : SEC_W'($urandom_range(0, 86399));
      send_request(day, sec);
    end
  endtask

  // drop valid at this edge so the last request is not offered twice
  task settle();
    query.valid <= 0;
    @(posedge clk);
    while (sb.answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task set_location(logic known, logic [CFG_W-1:0] lat, logic [CFG_W-1:0] lon);
    write_reg(CFG_LATITUDE, lat);
    write_reg(CFG_LONGITUDE, lon);
    write_reg(CFG_SPARE, CFG_W'($urandom));
    write_reg(CFG_LOCATION, {15'd0, known});
  endtask

  initial begin
    logic [DAY_W-1:0] days[8] = '{9'd1, 9'd80, 9'd172, 9'd266, 9'd355, 9'd366, 9'd0, 9'd511};
    logic [SEC_W-1:0] secs[5] = '{17'd0, 17'd43200, 17'd86399, 17'd100000, 17'd131071};
    logic [CFG_W-1:0] lats[9];
    logic [CFG_W-1:0] lons[9];
    lats = '{16'd4500, 16'd9000, -16'sd9000, 16'h3FFF, 16'h4000, 16'd6800, -16'sd6800,
             16'd0, 16'd2000};
    lons = '{-16'sd7500, 16'd18000, -16'sd18000, 16'h7FFF, 16'h8000, 16'd0, 16'd12345,
             16'd0, 16'd9000};
    rst = 1;
    cfg_we <= 0;
    cfg_index <= CFG_LOCATION;
    cfg_data <= '0;
    query.valid <= 0;
    query.day_of_year <= '0;
    query.second_of_day <= '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // location unknown after reset
    send_request(9'd0, 17'd0);
    send_request(9'd511, 17'd131071);
    send_request(9'd366, 17'd86399);
    settle();

    // high latitudes: normal window, polar night and polar day
    set_location(1, 16'd8000, -16'sd3000);
    for (int i = 0; i < 8; i++) send_request(days[i], secs[i % 5]);
    settle();
    set_location(1, 16'd9000, 16'd0);
    for (int i = 0; i < 5; i++) send_request(days[i], secs[i]);
    settle();
    set_location(1, -16'sd8500, 16'd17000);
    for (int i = 0; i < 6; i++) send_request(days[i], secs[(i + 2) % 5]);
    settle();

    for (int p = 0; p < 9; p++) begin
      set_location(1, lats[p], lons[p]);
      send_random(PHASE_ITEMS);
      settle();
    end
    set_location(1, CFG_W'($urandom_range(0, 18000) - 9000),
                 CFG_W'($urandom_range(0, 36000) - 18000));
    send_random(PHASE_ITEMS / 2);
    settle();
    write_reg(CFG_LOCATION, 16'd0);
    send_random(40);
    settle();

    if (sb.errors == 0 && sb.answer_q.size() == 0)
      $display("tb_solar_daylight_test: done, clean");
    else
      $display("tb_solar_daylight_test: done, errors");
    $finish;
  end

endmodule
